// ----- hdl/sdmap_pkg.sv -----
// ----------------------------------------------------------------------------
// sdmap_pkg
// Shared widths, register indexes and reset values for the step detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sdmap_pkg;

  // Sample and result field widths
  localparam int SAMPLE_W = 16;
  localparam int STEPS_W  = 16;
  localparam int COUNT_W  = 32;

  // Default ring depth (largest usable window)
  localparam int MAX_WINDOW_DEF = 64;

  // Serial divider dividend width (sample index and running sum share it)
  localparam int DIVIDEND_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_CFG_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd2;

  localparam logic [WIN_CFG_W-1:0]  WINDOW_LENGTH_RST  = 7'd25;
  localparam logic [CFG_DATA_W-1:0] MIN_STEP_GAP_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] PEAK_THRESHOLD_RST = 16'd2816;  // 11.0 in Q8.8

endpackage

`default_nettype wire

// ----- hdl/sdmap_if.sv -----
// ----------------------------------------------------------------------------
// sdmap_if
// Valid/ready channels of the step detector: samples, results, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdmap_sample_if;
  import sdmap_pkg::*;
  logic                valid;
  logic                ready;
  logic                restart;
  logic [SAMPLE_W-1:0] accel_magnitude;
  modport source (output valid, output restart, output accel_magnitude, input ready);
  modport sink   (input valid, input restart, input accel_magnitude, output ready);
endinterface

interface sdmap_result_if;
  import sdmap_pkg::*;
  logic                valid;
  logic                ready;
  logic [STEPS_W-1:0]  step_count;
  logic                peak_found;
  logic [SAMPLE_W-1:0] average_value;
  modport source (output valid, output step_count, output peak_found,
                  output average_value, input ready);
  modport sink   (input valid, input step_count, input peak_found,
                  input average_value, output ready);
endinterface

interface sdmap_cfg_if;
  import sdmap_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sdmap_div.sv -----
// ----------------------------------------------------------------------------
// sdmap_div
// Restoring serial divider, one quotient bit per cycle; narrow divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmap_div #(
  parameter int DIVISOR_W = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [sdmap_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]            divisor,
  output logic                                 done,
  output logic [sdmap_pkg::DIVIDEND_W-1:0]     quotient,
  output logic [DIVISOR_W-1:0]                 remainder
);
  import sdmap_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] rem_sub;
  logic             fits;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {remainder, quotient[DIVIDEND_W-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(DIVIDEND_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (active) begin
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
      remainder <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sdmap_ring.sv -----
// ----------------------------------------------------------------------------
// sdmap_ring
// Sample ring: single-port synchronous memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmap_ring #(
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      addr,
  input  wire logic [sdmap_pkg::SAMPLE_W-1:0] wdata,
  output logic [sdmap_pkg::SAMPLE_W-1:0]     rdata
);
  import sdmap_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/step_detect_moving_average_peak_unit.sv -----
// ----------------------------------------------------------------------------
// step_detect_moving_average_peak_unit
// Pedometer step detector: moving average over a sample ring, peak on slope
// turning negative above a threshold, with a minimum gap between steps.
// ----------------------------------------------------------------------------
// Accept to result valid: the first sample of a run skips the divider, a
// sample while the window fills takes one divider pass (average), and one
// once the window is full takes two passes (slot index and average).
// Throughput: one sample at a time; the serial divider sets the rate.
// Reset: synchronous; clears sum and counters, sets the slope flag, config to defaults.
// The sample ring has no reset; its read data is ignored while the window fills.
// ----------------------------------------------------------------------------
`default_nettype none

module step_detect_moving_average_peak_unit #(
  parameter int MAX_WINDOW = sdmap_pkg::MAX_WINDOW_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  sdmap_sample_if.sink    sample,
  sdmap_result_if.source  result,
  sdmap_cfg_if.sink       cfg
);
  import sdmap_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);        // ring address
  localparam int DW = $clog2(MAX_WINDOW + 1);    // window / divisor
  localparam int SW = SAMPLE_W + $clog2(MAX_WINDOW);  // running sum
  localparam logic [SW:0] SUM_MAX = (SW+1)'(MAX_WINDOW * 65535);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;  // slot = k mod window
  localparam logic [2:0] S_READ = 3'd2;  // ring read of the slot
  localparam logic [2:0] S_SUM  = 3'd3;  // update running sum
  localparam logic [2:0] S_DIVS = 3'd4;  // launch average division
  localparam logic [2:0] S_DIVW = 3'd5;  // wait for quotient
  localparam logic [2:0] S_OUT  = 3'd6;  // peak decision, commit, result

  logic [2:0] state;

  // configuration
  logic [WIN_CFG_W-1:0]  window_length;
  logic [CFG_DATA_W-1:0] min_step_gap;
  logic [CFG_DATA_W-1:0] peak_threshold;

  // run state
  logic [SW-1:0]       running_sum;
  logic [SAMPLE_W-1:0] previous_average;
  logic                previous_slope_nonneg;
  logic [COUNT_W-1:0]  last_step_index;
  logic [STEPS_W-1:0]  steps_so_far;
  logic [COUNT_W-1:0]  sample_count;

  // per-transaction working registers
  logic [SAMPLE_W-1:0] x_reg;
  logic                first_reg;
  logic                klt_reg;       // k below window: still filling
  logic [COUNT_W-1:0]  k_reg;
  logic [AW-1:0]       slot;
  logic [SAMPLE_W-1:0] avg;

  // result register
  logic                out_valid;
  logic [STEPS_W-1:0]  out_steps;
  logic                out_peak;
  logic [SAMPLE_W-1:0] out_avg;

  // ---------------------------------------------------------------------------
  // Effective window: 0 reads as 1, clamp to ring depth
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] w32;
  logic [DW-1:0]      weff;

  always_comb begin
    w32 = COUNT_W'(window_length);
    if (w32 == '0) begin
      w32 = COUNT_W'(1);
    end else if (w32 > COUNT_W'(MAX_WINDOW)) begin
      w32 = COUNT_W'(MAX_WINDOW);
    end
    weff = w32[DW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Accept: a new run starts on restart or when the counter sits at zero
  // ---------------------------------------------------------------------------
  logic               in_fire;
  logic               first_in;
  logic [COUNT_W-1:0] k_in;
  logic               klt_in;

  assign sample.ready = (state == S_IDLE);
  assign in_fire      = sample.valid && sample.ready;

  always_comb begin
    first_in = sample.restart || (sample_count == '0);
    k_in     = first_in ? '0 : sample_count;
    klt_in   = (k_in < w32);
  end

  // ---------------------------------------------------------------------------
  // Shared serial divider: k mod window, then sum / divisor
  // ---------------------------------------------------------------------------
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DW-1:0]         div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_q;
  logic [DW-1:0]         div_r;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVIDEND_W'(running_sum);
    div_divisor  = klt_reg ? (k_reg[DW-1:0] + DW'(1)) : weff;
    if (state == S_IDLE) begin
      div_start    = in_fire && !first_in && !klt_in;
      div_dividend = k_in;
      div_divisor  = weff;
    end else if (state == S_DIVS) begin
      div_start = 1'b1;
    end
  end

  sdmap_div #(
    .DIVISOR_W (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // ---------------------------------------------------------------------------
  // Sample ring: read old sample at the slot, write the new one on commit
  // ---------------------------------------------------------------------------
  logic                out_free;
  logic                commit;
  logic [SAMPLE_W-1:0] ring_rdata;

  assign out_free = !out_valid || result.ready;
  assign commit   = (state == S_OUT) && out_free;

  sdmap_ring #(
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .rd_en (state == S_READ),
    .wr_en (commit),
    .addr  (slot),
    .wdata (x_reg),
    .rdata (ring_rdata)
  );

  // ---------------------------------------------------------------------------
  // Running sum: add new, drop the oldest once full, floor at 0, clamp at max
  // ---------------------------------------------------------------------------
  logic [SW:0]   sum_tot;
  logic [SW:0]   sum_sub;
  logic [SW-1:0] sum_next;

  always_comb begin
    sum_tot = {1'b0, running_sum} + (SW+1)'(x_reg);
    if (klt_reg) begin
      sum_sub = sum_tot;
    end else if (sum_tot > (SW+1)'(ring_rdata)) begin
      sum_sub = sum_tot - (SW+1)'(ring_rdata);
    end else begin
      sum_sub = '0;
    end
    sum_next = (sum_sub > SUM_MAX) ? SUM_MAX[SW-1:0] : sum_sub[SW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Peak decision: slope turns negative, above threshold, past the step gap
  // ---------------------------------------------------------------------------
  logic               nonneg;
  logic               peak;
  logic [COUNT_W:0]   gap_end;
  logic [STEPS_W-1:0] steps_next;
  logic [COUNT_W-1:0] last_next;

  always_comb begin
    gap_end = {1'b0, last_step_index} + (COUNT_W+1)'(min_step_gap);
    nonneg  = first_reg || (avg >= previous_average);
    peak    = !first_reg && previous_slope_nonneg && !nonneg &&
              (avg > peak_threshold) && ({1'b0, k_reg} > gap_end);
    if (first_reg) begin
      steps_next = '0;
      last_next  = '0;
    end else if (peak) begin
      steps_next = (steps_so_far == '1) ? steps_so_far : steps_so_far + STEPS_W'(1);
      last_next  = k_reg;
    end else begin
      steps_next = steps_so_far;
      last_next  = last_step_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      running_sum           <= '0;
      previous_average      <= '0;
      previous_slope_nonneg <= 1'b1;
      last_step_index       <= '0;
      steps_so_far          <= '0;
      sample_count          <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (result.ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (first_in) begin
              state <= S_OUT;
            end else if (klt_in) begin
              state <= S_READ;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SUM;
        end
        S_SUM: begin
          running_sum <= sum_next;
          state       <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (first_reg) begin
              running_sum <= SW'(x_reg);
            end
            previous_average      <= avg;
            previous_slope_nonneg <= nonneg;
            last_step_index       <= last_next;
            steps_so_far          <= steps_next;
            sample_count          <= k_reg + COUNT_W'(1);  // wraps to zero: new run
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_reg     <= sample.accel_magnitude;
      first_reg <= first_in;
      klt_reg   <= klt_in;
      k_reg     <= k_in;
      slot      <= k_in[AW-1:0];            // k < window: slot is k itself
      avg       <= sample.accel_magnitude;  // first sample averages to itself
    end
    if ((state == S_MOD) && div_done) begin
      slot <= div_r[AW-1:0];
    end
    if ((state == S_DIVW) && div_done) begin
      avg <= (div_q[DIVIDEND_W-1:SAMPLE_W] != '0) ? '1 : div_q[SAMPLE_W-1:0];
    end
    if (commit) begin
      out_steps <= steps_next;
      out_peak  <= peak;
      out_avg   <= avg;
    end
  end

  assign result.valid         = out_valid;
  assign result.step_count    = out_steps;
  assign result.peak_found    = out_peak;
  assign result.average_value = out_avg;

  // ---------------------------------------------------------------------------
  // Configuration writes; out-of-range index is dropped
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_LENGTH_RST;
      min_step_gap   <= MIN_STEP_GAP_RST;
      peak_threshold <= PEAK_THRESHOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_WINDOW_LENGTH:  window_length  <= cfg.data[WIN_CFG_W-1:0];
        CFG_MIN_STEP_GAP:   min_step_gap   <= cfg.data;
        CFG_PEAK_THRESHOLD: peak_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
